// ===== rtl/core/pel_pkg.sv =====
// Package for the positional list engine: sizes, operation and status codes,
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pel_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = SLOT_W + 1;
  localparam logic signed [31:0] VALUE_LIMIT = 32'sd2000000000;

  localparam logic [2:0] OP_PUSH_BACK    = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT   = 3'd1;
  localparam logic [2:0] OP_POP_FRONT    = 3'd2;
  localparam logic [2:0] OP_INSERT_AFTER = 3'd3;
  localparam logic [2:0] OP_REMOVE_AFTER = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_BAD_POS   = 3'd2;
  localparam logic [2:0] ST_BAD_VALUE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_A,
    S_WALK_B,
    S_INS_A,
    S_INS_B,
    S_REMOVE,
    S_DONE
  } seq_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/positional_list_engine_core.sv =====
// Positional list engine: a bounded circular doubly linked list in node memories.
// Depends on pel_pkg.
//
// One request word in, one result word out. Push back and push front go from the
// checks straight to the insert states; pop front, insert after index p and remove
// after index p first walk the forward links from the head to node 0, p and p+1,
// one node per S_WALK_A/S_WALK_B pair, through the single registered read port
// of the node memories. Rejected requests go straight to the result. A new
// request is taken once the previous one has loaded the result register; that
// register holds a finished word while the next request runs, and a request that
// finishes while it is still full waits there.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          in_op,
  input  wire logic signed [31:0]  in_value,
  input  wire logic [7:0]          in_position,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_removed_value,
  output logic [2:0]               out_status,
  output logic [8:0]               out_count
);

  localparam int SW = pel_pkg::SLOT_W;
  localparam int CW = pel_pkg::CNT_W;

  // node and recycle memories
  logic [31:0] val_mem  [pel_pkg::CAPACITY];
  logic [SW-1:0] next_mem [pel_pkg::CAPACITY];
  logic [SW-1:0] prev_mem [pel_pkg::CAPACITY];
  logic [SW-1:0] stk_mem  [pel_pkg::CAPACITY];

  logic [31:0]   rd_val_r;
  logic [SW-1:0] rd_next_r, rd_prev_r, stk_rd_r;

  pel_pkg::seq_state_t state_r, state_nxt;
  logic [SW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt, top_r, top_nxt, fresh_r, fresh_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [2:0]    op_r, op_nxt, status_r, status_nxt;
  logic [31:0]   value_r, value_nxt, removed_r, removed_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [SW-1:0] cur_r, cur_nxt, slot_r, slot_nxt, nb_r, nb_nxt;
  logic [31:0]   o_rem_r, o_rem_nxt;
  logic [2:0]    o_st_r, o_st_nxt;
  logic [CW-1:0] o_cnt_r, o_cnt_nxt;

  logic          val_we, next_we, prev_we, stk_we;
  logic [SW-1:0] val_wa, next_wa, prev_wa, next_wd, prev_wd;
  logic [SW-1:0] stk_ra;

  logic bad_value, full, empty, accept;
  logic [CW-1:0] pos_ext, pos_plus;

  assign stk_ra    = top_r[SW-1:0] - SW'(1);
  assign bad_value = (in_value > pel_pkg::VALUE_LIMIT) || (in_value < -pel_pkg::VALUE_LIMIT);
  assign full      = (count_r >= CW'(pel_pkg::CAPACITY));
  assign empty     = (count_r == '0);
  assign pos_ext   = CW'(in_position);
  assign pos_plus  = pos_ext + CW'(1);
  assign in_ready  = (state_r == pel_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;

  // sequencer: checks, slot allocation, walk, link updates
  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r; tail_nxt = tail_r; count_nxt = count_r;
    top_nxt = top_r; fresh_nxt = fresh_r; out_valid_nxt = out_valid_r;
    op_nxt = op_r; status_nxt = status_r; value_nxt = value_r; removed_nxt = removed_r;
    steps_nxt = steps_r; cur_nxt = cur_r; slot_nxt = slot_r; nb_nxt = nb_r;
    o_rem_nxt = o_rem_r; o_st_nxt = o_st_r; o_cnt_nxt = o_cnt_r;
    val_we = 1'b0; next_we = 1'b0; prev_we = 1'b0; stk_we = 1'b0;
    val_wa = slot_r; next_wa = slot_r; prev_wa = slot_r;
    next_wd = slot_r; prev_wd = slot_r;

    // drop the result word once taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      pel_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt = in_op;
          value_nxt = in_value;
          removed_nxt = '0;
          status_nxt = pel_pkg::ST_OK;
          cur_nxt = head_r;
          state_nxt = pel_pkg::S_DONE;
          unique case (in_op)
            pel_pkg::OP_PUSH_BACK, pel_pkg::OP_PUSH_FRONT, pel_pkg::OP_INSERT_AFTER: begin
              if (in_op == pel_pkg::OP_INSERT_AFTER && pos_ext >= count_r)
                status_nxt = pel_pkg::ST_BAD_POS;
              else if (bad_value) status_nxt = pel_pkg::ST_BAD_VALUE;
              else if (full) status_nxt = pel_pkg::ST_FULL;
              else begin
                // take a recycled slot first, else a fresh one
                if (top_r != '0) begin
                  slot_nxt = stk_rd_r;
                  top_nxt = top_r - CW'(1);
                end else begin
                  slot_nxt = fresh_r[SW-1:0];
                  fresh_nxt = fresh_r + CW'(1);
                end
                steps_nxt = pos_ext;
                state_nxt = (in_op == pel_pkg::OP_INSERT_AFTER) ?
                            pel_pkg::S_WALK_A : pel_pkg::S_INS_A;
              end
            end
            pel_pkg::OP_POP_FRONT: begin
              if (empty) status_nxt = pel_pkg::ST_EMPTY;
              else begin
                steps_nxt = '0;
                state_nxt = pel_pkg::S_WALK_A;
              end
            end
            pel_pkg::OP_REMOVE_AFTER: begin
              if (pos_plus >= count_r) status_nxt = pel_pkg::ST_BAD_POS;
              else begin
                steps_nxt = pos_plus;
                state_nxt = pel_pkg::S_WALK_A;
              end
            end
            default: ;
          endcase
        end
      end

      // memories sample the node at cur_r
      pel_pkg::S_WALK_A: state_nxt = pel_pkg::S_WALK_B;

      // advance along the forward link, or stop at the target node
      pel_pkg::S_WALK_B: begin
        if (steps_r != '0) begin
          cur_nxt = rd_next_r;
          steps_nxt = steps_r - CW'(1);
          state_nxt = pel_pkg::S_WALK_A;
        end else if (op_r == pel_pkg::OP_INSERT_AFTER) begin
          nb_nxt = rd_next_r;
          state_nxt = pel_pkg::S_INS_A;
        end else begin
          state_nxt = pel_pkg::S_REMOVE;
        end
      end

      // write the new node and its own links
      pel_pkg::S_INS_A: begin
        val_we = 1'b1; next_we = 1'b1; prev_we = 1'b1;
        if (empty) begin
          next_wd = slot_r; prev_wd = slot_r;
        end else if (op_r == pel_pkg::OP_INSERT_AFTER) begin
          next_wd = nb_r; prev_wd = cur_r;
        end else begin
          next_wd = head_r; prev_wd = tail_r;
        end
        state_nxt = pel_pkg::S_INS_B;
      end

      // link the neighbors to the new node
      pel_pkg::S_INS_B: begin
        if (empty) begin
          head_nxt = slot_r; tail_nxt = slot_r;
        end else begin
          next_we = 1'b1; prev_we = 1'b1;
          next_wd = slot_r; prev_wd = slot_r;
          if (op_r == pel_pkg::OP_INSERT_AFTER) begin
            next_wa = cur_r; prev_wa = nb_r;
            if (cur_r == tail_r) tail_nxt = slot_r;
          end else begin
            next_wa = tail_r; prev_wa = head_r;
            if (op_r == pel_pkg::OP_PUSH_BACK) tail_nxt = slot_r;
            else head_nxt = slot_r;
          end
        end
        count_nxt = count_r + CW'(1);
        state_nxt = pel_pkg::S_DONE;
      end

      // unlink the node at cur_r and recycle its slot
      pel_pkg::S_REMOVE: begin
        removed_nxt = rd_val_r;
        if (count_r <= CW'(1)) begin
          head_nxt = '0; tail_nxt = '0;
        end else begin
          next_we = 1'b1; next_wa = rd_prev_r; next_wd = rd_next_r;
          prev_we = 1'b1; prev_wa = rd_next_r; prev_wd = rd_prev_r;
          if (cur_r == head_r) head_nxt = rd_next_r;
          if (cur_r == tail_r) tail_nxt = rd_prev_r;
        end
        stk_we = 1'b1;
        top_nxt = top_r + CW'(1);
        count_nxt = count_r - CW'(1);
        state_nxt = pel_pkg::S_DONE;
      end

      // load the result register when it is free
      pel_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          o_rem_nxt = removed_r;
          o_st_nxt = status_r;
          o_cnt_nxt = count_r;
          out_valid_nxt = 1'b1;
          state_nxt = pel_pkg::S_IDLE;
        end
      end

      default: state_nxt = pel_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pel_pkg::S_IDLE;
      head_r <= '0; tail_r <= '0; count_r <= '0;
      top_r <= '0; fresh_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; count_r <= count_nxt;
      top_r <= top_nxt; fresh_r <= fresh_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt; status_r <= status_nxt; value_r <= value_nxt;
    removed_r <= removed_nxt; steps_r <= steps_nxt; cur_r <= cur_nxt;
    slot_r <= slot_nxt; nb_r <= nb_nxt;
    o_rem_r <= o_rem_nxt; o_st_r <= o_st_nxt; o_cnt_r <= o_cnt_nxt;
  end

  // node memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= value_r;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    rd_val_r <= val_mem[cur_r];
    rd_next_r <= next_mem[cur_r];
    rd_prev_r <= prev_mem[cur_r];
  end

  // recycle stack: read the top entry every cycle
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[top_r[SW-1:0]] <= cur_r;
    stk_rd_r <= stk_mem[stk_ra];
  end

  assign out_valid = out_valid_r;
  assign out_removed_value = o_rem_r;
  assign out_status = o_st_r;
  assign out_count = o_cnt_r;

endmodule
`default_nettype wire
